[rtl/fgr_pkg.sv]
// Package for the glyph and rectangle drawer: payload structs, action codes,
// font ROM and RGB565 expansion. No dependencies.
package fgr_pkg;

  typedef enum logic [2:0] {
    ACT_FILL = 3'd0,
    ACT_RECT = 3'd1,
    ACT_BORDER = 3'd2,
    ACT_CHAR = 3'd3,
    ACT_READ = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [10:0] box_width;
    logic [10:0] box_height;
    logic [15:0] color;
    logic [15:0] back_color;
    logic [7:0]  char_code;
    logic [3:0]  scale;
  } cmd_t;

  typedef struct packed {
    logic signed [12:0] next_x;
    logic [23:0] pixel_rgb;
    logic        read_ok;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_READ,
    ST_WAIT,
    ST_OUT
  } state_e;

  // Box walk plan handed from the sequencer to the drawing unit.
  typedef struct packed {
    logic               start;
    logic signed [13:0] x0;
    logic signed [13:0] y0;
    logic signed [13:0] x1;
    logic signed [13:0] y1;
    logic [15:0]        color;
  } box_t;

  localparam logic [7:0] GlyphFirst = 8'h20;
  localparam logic [7:0] GlyphLast  = 8'h7E;
  localparam int unsigned GlyphAdvance = 5 + 1;

  function automatic logic [39:0] glyph_cols(input logic [7:0] code);
    logic [7:0] c;
    logic [39:0] r;
    c = (code < GlyphFirst || code > GlyphLast) ? 8'h3F : code;
    case (c)
      8'h20: r = 40'h0000000000; 8'h21: r = 40'h00005F0000; 8'h22: r = 40'h0007000700;
      8'h23: r = 40'h147F147F14; 8'h24: r = 40'h242A7F2A12; 8'h25: r = 40'h2313086462;
      8'h26: r = 40'h3649552250; 8'h27: r = 40'h0005030000; 8'h28: r = 40'h001C224100;
      8'h29: r = 40'h0041221C00; 8'h2A: r = 40'h14083E0814; 8'h2B: r = 40'h08083E0808;
      8'h2C: r = 40'h0050300000; 8'h2D: r = 40'h0808080808; 8'h2E: r = 40'h0060600000;
      8'h2F: r = 40'h2010080402; 8'h30: r = 40'h3E5149453E; 8'h31: r = 40'h00427F4000;
      8'h32: r = 40'h4261514946; 8'h33: r = 40'h2141454B31; 8'h34: r = 40'h1814127F10;
      8'h35: r = 40'h2745454539; 8'h36: r = 40'h3C4A494930; 8'h37: r = 40'h0171090503;
      8'h38: r = 40'h3649494936; 8'h39: r = 40'h064949291E; 8'h3A: r = 40'h0036360000;
      8'h3B: r = 40'h0056360000; 8'h3C: r = 40'h0814224100; 8'h3D: r = 40'h1414141414;
      8'h3E: r = 40'h0041221408; 8'h3F: r = 40'h0201510906; 8'h40: r = 40'h324979413E;
      8'h41: r = 40'h7E1111117E; 8'h42: r = 40'h7F49494936; 8'h43: r = 40'h3E41414122;
      8'h44: r = 40'h7F4141221C; 8'h45: r = 40'h7F49494941; 8'h46: r = 40'h7F09090901;
      8'h47: r = 40'h3E4149497A; 8'h48: r = 40'h7F0808087F; 8'h49: r = 40'h00417F4100;
      8'h4A: r = 40'h2040413F01; 8'h4B: r = 40'h7F08142241; 8'h4C: r = 40'h7F40404040;
      8'h4D: r = 40'h7F020C027F; 8'h4E: r = 40'h7F0408107F; 8'h4F: r = 40'h3E4141413E;
      8'h50: r = 40'h7F09090906; 8'h51: r = 40'h3E4151215E; 8'h52: r = 40'h7F09192946;
      8'h53: r = 40'h4649494931; 8'h54: r = 40'h01017F0101; 8'h55: r = 40'h3F4040403F;
      8'h56: r = 40'h1F2040201F; 8'h57: r = 40'h3F4038403F; 8'h58: r = 40'h6314081463;
      8'h59: r = 40'h0708700807; 8'h5A: r = 40'h6151494543; 8'h5B: r = 40'h007F414100;
      8'h5C: r = 40'h0204081020; 8'h5D: r = 40'h0041417F00; 8'h5E: r = 40'h0402010204;
      8'h5F: r = 40'h4040404040; 8'h60: r = 40'h0001020400; 8'h61: r = 40'h2054545478;
      8'h62: r = 40'h7F48444438; 8'h63: r = 40'h3844444420; 8'h64: r = 40'h384444487F;
      8'h65: r = 40'h3854545418; 8'h66: r = 40'h087E090102; 8'h67: r = 40'h0C5252523E;
      8'h68: r = 40'h7F08040478; 8'h69: r = 40'h00447D4000; 8'h6A: r = 40'h2040443D00;
      8'h6B: r = 40'h7F10284400; 8'h6C: r = 40'h00417F4000; 8'h6D: r = 40'h7C04180478;
      8'h6E: r = 40'h7C08040478; 8'h6F: r = 40'h3844444438; 8'h70: r = 40'h7C14141408;
      8'h71: r = 40'h081414187C; 8'h72: r = 40'h7C08040408; 8'h73: r = 40'h4854545420;
      8'h74: r = 40'h043F444020; 8'h75: r = 40'h3C4040207C; 8'h76: r = 40'h1C2040201C;
      8'h77: r = 40'h3C4030403C; 8'h78: r = 40'h4428102844; 8'h79: r = 40'h0C5050503C;
      8'h7A: r = 40'h4464544C44; 8'h7B: r = 40'h0008364100; 8'h7C: r = 40'h00007F0000;
      8'h7D: r = 40'h0041360800; 8'h7E: r = 40'h1008081008;
      default: r = 40'h0201510906;
    endcase
    return r;
  endfunction

  // c*255/31 = 8c + floor(7c/31); the floor term steps at c = 5, 9, 14, 18,
  // 23, 27 and 31.
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [2:0] k;
    k = '0;
    if (c >= 5'd5)  k = k + 3'd1;
    if (c >= 5'd9)  k = k + 3'd1;
    if (c >= 5'd14) k = k + 3'd1;
    if (c >= 5'd18) k = k + 3'd1;
    if (c >= 5'd23) k = k + 3'd1;
    if (c >= 5'd27) k = k + 3'd1;
    if (c >= 5'd31) k = k + 3'd1;
    return {c, 3'b000} + {5'd0, k};
  endfunction

  // c*255/63 = 4c + floor(c/21).
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [1:0] k;
    k = '0;
    if (c >= 6'd21) k = k + 2'd1;
    if (c >= 6'd42) k = k + 2'd1;
    if (c >= 6'd63) k = k + 2'd1;
    return {c, 2'b00} + {6'd0, k};
  endfunction

  function automatic logic [23:0] rgb_expand(input logic [15:0] p);
    return {expand5(p[15:11]), expand6(p[10:5]), expand5(p[4:0])};
  endfunction

endpackage

[rtl/framebuffer_glyph_and_rect_drawer.sv]
// Top level of the glyph and rectangle drawer over an RGB565 frame store.
// Depends on fgr_pkg, fgr_sequencer and fgr_box_walker.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------
//  cmd     | in        | cmd_valid/ready    | cmd_t
//  rsp     | out       | rsp_valid/ready    | rsp_t
//
// Flow: a command is split into boxes (one, four for a border, 35 for a
// glyph); each box is written one clipped pixel at a time, as the single
// memory write port takes one pixel a cycle. One command at a time;
// response held until taken.
// Reset clears control only; the frame store holds garbage until filled.
module framebuffer_glyph_and_rect_drawer import fgr_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);
  box_t        box;
  logic        walk_busy;
  logic        rd_en;
  logic [11:0] rd_x, rd_y;
  logic [15:0] rd_data;

  fgr_sequencer #(.ScreenWidth(SCREEN_WIDTH), .ScreenHeight(SCREEN_HEIGHT)) u_seq (
    .clk_i, .rst_ni, .cmd_valid_i, .cmd_ready_o, .cmd_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o,
    .box_o(box), .walk_busy_i(walk_busy),
    .rd_en_o(rd_en), .rd_x_o(rd_x), .rd_y_o(rd_y), .rd_data_i(rd_data)
  );

  fgr_box_walker #(.ScreenWidth(SCREEN_WIDTH), .ScreenHeight(SCREEN_HEIGHT)) u_walk (
    .clk_i, .rst_ni, .box_i(box), .busy_o(walk_busy),
    .rd_en_i(rd_en), .rd_x_i(rd_x), .rd_y_i(rd_y), .rd_data_o(rd_data)
  );
endmodule

[rtl/fgr_box_walker.sv]
// Walks a clipped box one pixel per cycle and owns the frame store memory.
// Depends on fgr_pkg.
module fgr_box_walker import fgr_pkg::*; #(
  parameter int unsigned ScreenWidth = 320,
  parameter int unsigned ScreenHeight = 240
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  box_t        box_i,
  output logic        busy_o,
  input  logic        rd_en_i,
  input  logic [11:0] rd_x_i,
  input  logic [11:0] rd_y_i,
  output logic [15:0] rd_data_o
);
  localparam int unsigned Depth = ScreenWidth * ScreenHeight;
  localparam int unsigned AW = $clog2(Depth);
  localparam logic signed [13:0] XLim = 14'(ScreenWidth);
  localparam logic signed [13:0] YLim = 14'(ScreenHeight);

  logic [15:0] mem [Depth];
  logic        busy_q, busy_d;
  logic [10:0] x_q, x_d, y_q, y_d, xs_q, xs_d, xe_q, xe_d, ye_q, ye_d;
  logic [AW-1:0] row_q, row_d;
  logic [15:0] col_q, col_d;
  logic signed [13:0] cx0, cy0, cx1, cy1;

  always_comb begin
    cx0 = box_i.x0 < 0 ? '0 : box_i.x0;
    cy0 = box_i.y0 < 0 ? '0 : box_i.y0;
    cx1 = box_i.x1 > XLim ? XLim : box_i.x1;
    cy1 = box_i.y1 > YLim ? YLim : box_i.y1;
    busy_d = busy_q; x_d = x_q; y_d = y_q; xs_d = xs_q; xe_d = xe_q; ye_d = ye_q;
    row_d = row_q; col_d = col_q;
    if (!busy_q && box_i.start) begin
      if (cx0 < cx1 && cy0 < cy1) begin
        busy_d = 1'b1;
        x_d = 11'(cx0); xs_d = 11'(cx0); xe_d = 11'(cx1 - 14'sd1);
        y_d = 11'(cy0); ye_d = 11'(cy1 - 14'sd1);
        row_d = AW'(32'(cy0) * ScreenWidth);
        col_d = box_i.color;
      end
    end else if (busy_q) begin
      if (x_q == xe_q) begin
        x_d = xs_q;
        y_d = y_q + 11'd1;
        row_d = row_q + AW'(ScreenWidth);
        if (y_q == ye_q) busy_d = 1'b0;
      end else begin
        x_d = x_q + 11'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; xs_q <= xs_d; xe_q <= xe_d; ye_q <= ye_d;
    row_q <= row_d; col_q <= col_d;
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) mem[row_q + AW'(x_q)] <= col_q;
    if (rd_en_i) rd_data_o <= mem[AW'(32'(rd_y_i) * ScreenWidth) + AW'(rd_x_i)];
  end

  assign busy_o = busy_q | box_i.start;

`ifndef SYNTHESIS
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (32'(row_q) + 32'(x_q) < Depth)) else $error("write out of range");
  a_x_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (x_q <= xe_q && y_q <= ye_q)) else $error("walker overran box");
  a_no_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !rd_en_i) else $error("read during draw");
`endif
endmodule

[rtl/fgr_sequencer.sv]
// Command sequencer: splits each drawing command into boxes for the walker and performs pixel reads.
// Depends on fgr_pkg.
module fgr_sequencer import fgr_pkg::*; #(
  parameter int unsigned ScreenWidth = 320,
  parameter int unsigned ScreenHeight = 240
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output rsp_t        rsp_o,
  output box_t        box_o,
  input  logic        walk_busy_i,
  output logic        rd_en_o,
  output logic [11:0] rd_x_o,
  output logic [11:0] rd_y_o,
  input  logic [15:0] rd_data_i
);
  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  rsp_t   rsp_q, rsp_d;
  logic [5:0] step_q, step_d;   // box index within the command; all ones while a read is pending
  logic [2:0] gc_q, gc_d, gr_q, gr_d;   // glyph column and row of the current dot
  logic [39:0] cols;
  logic signed [13:0] px, py, bw, bh, sc;
  logic        in_range;
  logic        last;

  assign px = 14'(cmd_q.pos_x);
  assign py = 14'(cmd_q.pos_y);
  assign bw = 14'({1'b0, cmd_q.box_width});
  assign bh = 14'({1'b0, cmd_q.box_height});
  assign sc = 14'({1'b0, cmd_q.scale});
  assign cols = glyph_cols(cmd_q.char_code);
  assign in_range = !cmd_q.pos_x[11] && !cmd_q.pos_y[11]
                    && 32'(cmd_q.pos_x) < ScreenWidth && 32'(cmd_q.pos_y) < ScreenHeight;

  always_comb begin
    box_o = '0;
    box_o.color = cmd_q.color;
    last = 1'b1;
    case (cmd_q.action)
      ACT_FILL: begin
        box_o.x1 = 14'(ScreenWidth); box_o.y1 = 14'(ScreenHeight);
      end
      ACT_RECT: begin
        box_o.x0 = px; box_o.y0 = py; box_o.x1 = px + bw; box_o.y1 = py + bh;
      end
      ACT_BORDER: begin
        last = (step_q == 6'd3);
        case (step_q[1:0])
          2'd0: begin
            box_o.x0 = px; box_o.y0 = py; box_o.x1 = px + bw; box_o.y1 = py + 14'sd1;
          end
          2'd1: begin
            box_o.x0 = px; box_o.y0 = py + bh - 14'sd1;
            box_o.x1 = px + bw; box_o.y1 = py + bh;
          end
          2'd2: begin
            box_o.x0 = px; box_o.y0 = py; box_o.x1 = px + 14'sd1; box_o.y1 = py + bh;
          end
          default: begin
            box_o.x0 = px + bw - 14'sd1; box_o.y0 = py;
            box_o.x1 = px + bw; box_o.y1 = py + bh;
          end
        endcase
      end
      ACT_CHAR: begin
        last = (gc_q == 3'd4) && (gr_q == 3'd6);
        box_o.x0 = px + 14'(gc_q) * sc;
        box_o.y0 = py + 14'(gr_q) * sc;
        box_o.x1 = box_o.x0 + sc;
        box_o.y1 = box_o.y0 + sc;
        box_o.color = cols[6'(39 - 8 * gc_q) - 6'(7 - gr_q)] ? cmd_q.color
                                                            : cmd_q.back_color;
      end
      default: ;
    endcase
    box_o.start = (state_q == ST_DRAW);
  end

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; rsp_d = rsp_q; step_d = step_q;
    gc_d = gc_q; gr_d = gr_q;
    cmd_ready_o = 1'b0; rd_en_o = 1'b0;
    rd_x_o = cmd_q.pos_x; rd_y_o = cmd_q.pos_y;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_i; step_d = '0; rsp_d = '0;
          gc_d = '0; gr_d = '0;
          if (cmd_i.action == ACT_CHAR)
            rsp_d.next_x = 13'(cmd_i.pos_x) + 13'(GlyphAdvance) * 13'(cmd_i.scale);
          if (cmd_i.action == ACT_READ) state_d = ST_READ;
          else if (cmd_i.action inside {ACT_FILL, ACT_RECT, ACT_BORDER, ACT_CHAR})
            state_d = ST_DRAW;
          else state_d = ST_OUT;
        end
      end
      ST_DRAW: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (!walk_busy_i) begin
          if (last) state_d = ST_OUT;
          else begin
            step_d = step_q + 6'd1;
            if (gr_q == 3'd6) begin
              gr_d = '0;
              gc_d = gc_q + 3'd1;
            end else begin
              gr_d = gr_q + 3'd1;
            end
            state_d = ST_DRAW;
          end
        end
      end
      ST_READ: begin
        rd_en_o = in_range;
        state_d = in_range ? ST_WAIT : ST_OUT;
        step_d = '1;
      end
      ST_OUT: begin
        if (rsp_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_WAIT && step_q == '1 && cmd_q.action == ACT_READ) begin
      rsp_d.pixel_rgb = rgb_expand(rd_data_i);
      rsp_d.read_ok = 1'b1;
      state_d = ST_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; rsp_q <= rsp_d; step_q <= step_d;
    gc_q <= gc_d; gr_q <= gr_d;
  end

  assign rsp_valid_o = (state_q == ST_OUT);
  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_ready_i |=> state_q == ST_IDLE) else $error("bad return");
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> !rsp_valid_o && !walk_busy_i) else $error("ready while busy");
  a_start_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_o.start |=> state_q == ST_WAIT) else $error("start without wait");
`endif
endmodule
